@@ hdl/pfa_pkg.sv @@
package pfa_pkg;

  // Default geometry
  localparam int NUM_PROCESSES_DEF     = 8;
  localparam int PAGES_PER_PROCESS_DEF = 64;
  localparam int NUM_FRAMES_DEF        = 64;
  localparam int WS_DEPTH_DEF          = 8;

  // Register and counter widths fixed by the interface
  localparam int LIMIT_W = 4;
  localparam int STAMP_W = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8);

  // Result outcome codes
  localparam logic [1:0] OUT_HIT  = 2'd0;
  localparam logic [1:0] OUT_FREE = 2'd1;
  localparam logic [1:0] OUT_SWAP = 2'd2;
  localparam logic [1:0] OUT_REPL = 2'd3;

endpackage

@@ hdl/pfa_ram.sv @@
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/paged_frame_allocator_lru.sv @@
// Paged frame allocator with per-process LRU replacement.
//
// Request channel (in_valid/in_ready, req_proc, req_page) takes one page
// request per transaction. Result channel (out_valid/out_ready, frame, outcome,
// victim_process, victim_page) returns exactly one result per request, in order.
// Config channel (cfg_valid/cfg_ready, resident_limit) is always ready; write
// it only while no request is in flight.
//
// A hit searches and reorders the process's LRU list, a free-frame miss pops the
// free stack, and an own-page replacement evicts the least-recent page and then
// reorders the list. A miss below the limit with an empty free stack scans all
// NUM_PROCESSES stamps (one per cycle), then walks the victim's page table.
// in_ready returns in the same cycle as out_valid rises; one request is in work.
//
// Reset: a clearing pass zeroes the page-table valid bits and loads the free
// stack; in_ready stays low meanwhile. A result held by a stalled receiver sits
// in the output register; the next request is still taken and only its
// write-back waits.
module paged_frame_allocator_lru
  import pfa_pkg::*;
#(
  parameter int NUM_PROCESSES     = NUM_PROCESSES_DEF,
  parameter int PAGES_PER_PROCESS = PAGES_PER_PROCESS_DEF,
  parameter int NUM_FRAMES        = NUM_FRAMES_DEF,
  parameter int WS_DEPTH          = WS_DEPTH_DEF,
  localparam int PW  = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1,
  localparam int GW  = (PAGES_PER_PROCESS > 1) ? $clog2(PAGES_PER_PROCESS) : 1,
  localparam int FW  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] resident_limit,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PW-1:0]      req_proc,
  input  logic [GW-1:0]      req_page,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FW-1:0]      frame,
  output logic [1:0]         outcome,
  output logic [PW-1:0]      victim_process,
  output logic [GW-1:0]      victim_page
);

  localparam int PT_DEPTH  = NUM_PROCESSES * PAGES_PER_PROCESS;
  localparam int LRU_DEPTH = NUM_PROCESSES * WS_DEPTH;
  localparam int TW  = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;
  localparam int LW  = (LRU_DEPTH > 1) ? $clog2(LRU_DEPTH) : 1;
  localparam int CW  = $clog2(WS_DEPTH + 1);
  localparam int FCW = $clog2(NUM_FRAMES + 1);
  localparam int CLR_N = (PT_DEPTH > NUM_FRAMES) ? PT_DEPTH : NUM_FRAMES;
  localparam int CLW = $clog2(CLR_N + 1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_HRD, S_HCMP, S_SRD, S_SWR, S_LAST,
    S_RRD, S_RPT, S_RWR1, S_RWR2, S_VSCAN, S_ERD, S_EWR, S_PRD, S_PWR, S_FIN
  } state_t;

  state_t state;

  // Control and work registers
  logic [LIMIT_W-1:0] wsl;
  logic [CLW-1:0]     ccnt;
  logic [PW-1:0]      p_r;
  logic [GW-1:0]      pg_r;
  logic [TW-1:0]      slot_r;
  logic [LW-1:0]      lbase_r;
  logic [CW-1:0]      cnt_r;
  logic [CW-1:0]      i_r;
  logic [PW-1:0]      pidx;
  logic [GW-1:0]      ep;
  logic [FW-1:0]      fr_r;
  logic [1:0]         oc_r;
  logic [PW-1:0]      vp_r;
  logic [GW-1:0]      vpg_r;
  logic [PW-1:0]      best_r;
  logic [STAMP_W-1:0] best_stamp;
  logic               found_r;
  logic [FCW-1:0]     fcount;
  logic [STAMP_W-1:0] seq;

  logic [CW-1:0]      count_arr [NUM_PROCESSES];
  logic [STAMP_W-1:0] stamp_arr [NUM_PROCESSES];

  // Memory ports
  logic            pt_we;
  logic [TW-1:0]   pt_waddr, pt_raddr;
  logic [FW:0]     pt_wdata, pt_rdata;
  logic            lru_we;
  logic [LW-1:0]   lru_waddr, lru_raddr;
  logic [GW-1:0]   lru_wdata, lru_rdata;
  logic            st_we;
  logic [FW-1:0]   st_waddr, st_raddr;
  logic [FW-1:0]   st_wdata, st_rdata;

  pfa_ram #(.WIDTH(FW + 1), .DEPTH(PT_DEPTH)) u_pt (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  pfa_ram #(.WIDTH(GW), .DEPTH(LRU_DEPTH)) u_lru (
    .clk(clk), .we(lru_we), .waddr(lru_waddr), .wdata(lru_wdata),
    .raddr(lru_raddr), .rdata(lru_rdata)
  );

  pfa_ram #(.WIDTH(FW), .DEPTH(NUM_FRAMES)) u_stack (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  // Input wrap: the field is below twice the count, so one compare-subtract
  logic [PW-1:0] in_p;
  logic [GW-1:0] in_pg;
  logic [TW-1:0] in_slot;
  logic [GW-1:0] old_pg;
  logic [TW-1:0] old_slot;
  logic [TW-1:0] ev_slot;
  logic [7:0]    lim;
  logic [CW-1:0] cur_cnt;
  logic [STAMP_W-1:0] cur_stamp;
  logic          take;
  logic [PW-1:0] best_next;
  logic          found_next;

  always_comb begin
    in_p  = (32'(req_proc) >= NUM_PROCESSES) ?
            PW'(32'(req_proc) - NUM_PROCESSES) : req_proc;
    in_pg = (32'(req_page) >= PAGES_PER_PROCESS) ?
            GW'(32'(req_page) - PAGES_PER_PROCESS) : req_page;
    in_slot = TW'(32'(in_p) * PAGES_PER_PROCESS + 32'(in_pg));
    old_pg = (32'(lru_rdata) >= PAGES_PER_PROCESS) ?
             GW'(32'(lru_rdata) - PAGES_PER_PROCESS) : lru_rdata;
    old_slot = TW'(32'(p_r) * PAGES_PER_PROCESS + 32'(vpg_r));
    ev_slot  = TW'(32'(pidx) * PAGES_PER_PROCESS + 32'(ep));
    // Limit clamped to 1..WS_DEPTH
    if (wsl == '0) begin
      lim = 8'd1;
    end else if (32'(wsl) > WS_DEPTH) begin
      lim = 8'(WS_DEPTH);
    end else begin
      lim = 8'(wsl);
    end
    cur_cnt   = count_arr[pidx];
    cur_stamp = stamp_arr[pidx];
    // Oldest nonzero-count process; ties keep the lower number
    take = (cur_cnt != '0) && (!found_r || (cur_stamp < best_stamp));
    best_next  = take ? pidx : best_r;
    found_next = found_r | take;
  end

  // Memory port steering
  always_comb begin
    pt_we     = 1'b0;
    pt_waddr  = slot_r;
    pt_wdata  = {1'b1, fr_r};
    pt_raddr  = in_slot;
    lru_we    = 1'b0;
    lru_waddr = LW'(32'(lbase_r) + 32'(i_r) - 1);
    lru_wdata = lru_rdata;
    lru_raddr = LW'(32'(lbase_r) + 32'(i_r));
    st_we     = 1'b0;
    st_waddr  = FW'(fcount);
    st_wdata  = pt_rdata[FW-1:0];
    st_raddr  = FW'(32'(fcount) - 1);
    unique case (state)
      S_CLEAR: begin
        pt_we    = (32'(ccnt) < PT_DEPTH);
        pt_waddr = TW'(ccnt);
        pt_wdata = '0;
        st_we    = (32'(ccnt) < NUM_FRAMES);
        st_waddr = FW'(ccnt);
        st_wdata = FW'(NUM_FRAMES - 1 - 32'(ccnt));
      end
      S_SWR: begin
        lru_we = 1'b1;
      end
      S_LAST: begin
        lru_we    = 1'b1;
        lru_waddr = LW'(32'(lbase_r) + 32'(cnt_r) - 1);
        lru_wdata = pg_r;
      end
      S_RRD: begin
        lru_raddr = lbase_r;
      end
      S_RPT: begin
        pt_raddr = TW'(32'(p_r) * PAGES_PER_PROCESS + 32'(old_pg));
      end
      S_RWR1: begin
        pt_we    = 1'b1;
        pt_waddr = old_slot;
        pt_wdata = {1'b0, pt_rdata[FW-1:0]};
      end
      S_RWR2: begin
        pt_we = 1'b1;
      end
      S_ERD: begin
        pt_raddr = ev_slot;
      end
      S_EWR: begin
        pt_we    = 1'b1;
        pt_waddr = ev_slot;
        pt_wdata = {1'b0, pt_rdata[FW-1:0]};
        st_we    = pt_rdata[FW] && (32'(fcount) < NUM_FRAMES);
      end
      S_PWR: begin
        pt_we     = 1'b1;
        pt_wdata  = {1'b1, st_rdata};
        lru_we    = (32'(cur_cnt) < WS_DEPTH);
        lru_waddr = LW'(32'(lbase_r) + 32'(cur_cnt));
        lru_wdata = pg_r;
      end
      default: begin
      end
    endcase
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ccnt      <= '0;
      wsl       <= LIMIT_RESET;
      fcount    <= FCW'(NUM_FRAMES);
      seq       <= STAMP_W'(1);
      out_valid <= 1'b0;
      found_r   <= 1'b0;
      for (int k = 0; k < NUM_PROCESSES; k++) begin
        count_arr[k] <= '0;
        stamp_arr[k] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        wsl <= resident_limit;
      end
      // S_FIN reloads the register itself when it drains in the same cycle
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          ccnt <= ccnt + 1'b1;
          if (32'(ccnt) == CLR_N - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            p_r     <= in_p;
            pg_r    <= in_pg;
            slot_r  <= in_slot;
            lbase_r <= LW'(32'(in_p) * WS_DEPTH);
            pidx    <= in_p;
            vp_r    <= '0;
            vpg_r   <= '0;
            state   <= S_LOOK;
          end
        end
        S_LOOK: begin
          cnt_r <= cur_cnt;
          if (pt_rdata[FW]) begin
            oc_r <= OUT_HIT;
            fr_r <= pt_rdata[FW-1:0];
            i_r  <= '0;
            state <= (cur_cnt == '0) ? S_FIN : S_HRD;
          end else if (8'(cur_cnt) < lim) begin
            if (fcount == '0) begin
              oc_r    <= OUT_SWAP;
              pidx    <= '0;
              found_r <= 1'b0;
              state   <= S_VSCAN;
            end else begin
              oc_r  <= OUT_FREE;
              state <= S_PRD;
            end
          end else begin
            oc_r  <= OUT_REPL;
            state <= S_RRD;
          end
        end
        // Hit: find the page in the LRU list
        S_HRD: begin
          state <= S_HCMP;
        end
        S_HCMP: begin
          if (lru_rdata == pg_r) begin
            i_r   <= i_r + 1'b1;
            state <= S_SRD;
          end else if (i_r == cnt_r - 1'b1) begin
            // not listed: overwrite the most-recent entry
            i_r   <= cnt_r;
            state <= S_SRD;
          end else begin
            i_r   <= i_r + 1'b1;
            state <= S_HRD;
          end
        end
        // Shift entries above the hole down by one
        S_SRD: begin
          state <= (i_r < cnt_r) ? S_SWR : S_LAST;
        end
        S_SWR: begin
          i_r   <= i_r + 1'b1;
          state <= S_SRD;
        end
        S_LAST: begin
          state <= S_FIN;
        end
        // Replace own least-recent page
        S_RRD: begin
          state <= S_RPT;
        end
        S_RPT: begin
          vpg_r <= old_pg;
          state <= S_RWR1;
        end
        S_RWR1: begin
          fr_r  <= pt_rdata[FW-1:0];
          state <= S_RWR2;
        end
        S_RWR2: begin
          i_r   <= CW'(1);
          state <= S_SRD;
        end
        // Swap-out victim search
        S_VSCAN: begin
          best_r     <= best_next;
          best_stamp <= take ? cur_stamp : best_stamp;
          found_r    <= found_next;
          if (32'(pidx) == NUM_PROCESSES - 1) begin
            if (found_next) begin
              pidx  <= best_next;
              vp_r  <= best_next;
              ep    <= '0;
              state <= S_ERD;
            end else begin
              pidx  <= p_r;
              state <= S_PRD;
            end
          end else begin
            pidx <= pidx + 1'b1;
          end
        end
        S_ERD: begin
          state <= S_EWR;
        end
        S_EWR: begin
          if (pt_rdata[FW] && (32'(fcount) < NUM_FRAMES)) begin
            fcount <= fcount + 1'b1;
          end
          if (32'(ep) == PAGES_PER_PROCESS - 1) begin
            count_arr[pidx] <= '0;
            pidx  <= p_r;
            state <= S_PRD;
          end else begin
            ep    <= ep + 1'b1;
            state <= S_ERD;
          end
        end
        // Pop a free frame
        S_PRD: begin
          if (fcount == '0) begin
            fr_r  <= '0;
            vp_r  <= '0;
            state <= S_FIN;
          end else begin
            state <= S_PWR;
          end
        end
        S_PWR: begin
          fr_r   <= st_rdata;
          fcount <= fcount - 1'b1;
          if (32'(cur_cnt) < WS_DEPTH) begin
            count_arr[pidx] <= cur_cnt + 1'b1;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            frame           <= fr_r;
            outcome         <= oc_r;
            victim_process  <= vp_r;
            victim_page     <= vpg_r;
            stamp_arr[pidx] <= seq;
            seq             <= seq + 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
